// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pstc: assertion failed");

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pstc: reset assertion failed");

`endif

// ----- hw/rtl/pstc_pkg.sv -----
// ----------------------------------------------------------------------------
// pstc_pkg
// Shared constants, register codes and arithmetic helpers of the polar scan
// to Cartesian converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pstc_pkg;

    // Beams in one sensor revolution; must be a power of two.
    localparam int BEAMS_PER_TURN = 1024;
    localparam int BASE_SHIFT     = $clog2(BEAMS_PER_TURN);

    // Register stages from the input register to the output register.
    localparam int PIPE_DEPTH = 17;

    localparam int CFG_DATA_W = 17;

    typedef enum logic [1:0] {
        CFG_MIRROR   = 2'd0,
        CFG_ROTATION = 2'd1,
        CFG_OFFSET_X = 2'd2,
        CFG_OFFSET_Y = 2'd3
    } t_cfg_index;

    // Angle offsets in binary angle units: -45 degrees and -135 degrees.
    localparam logic [15:0] ANG_OFS_NORMAL = 16'hE000;
    localparam logic [15:0] ANG_OFS_MIRROR = 16'hA000;
    localparam logic [15:0] ANG_QUARTER_HALF = 16'h2000;

    // 2*pi in Q28, so that |t| * TWO_PI_Q28 >> 14 is the residue in Q30 radians.
    localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

    // Reciprocals floor(2^32 / d) for the Horner divisions.
    localparam logic [31:0] RECIP_42 = 32'((64'd1 << 32) / 64'd42);
    localparam logic [31:0] RECIP_20 = 32'((64'd1 << 32) / 64'd20);
    localparam logic [31:0] RECIP_6  = 32'((64'd1 << 32) / 64'd6);
    localparam logic [31:0] RECIP_56 = 32'((64'd1 << 32) / 64'd56);
    localparam logic [31:0] RECIP_30 = 32'((64'd1 << 32) / 64'd30);
    localparam logic [31:0] RECIP_12 = 32'((64'd1 << 32) / 64'd12);

    localparam logic [5:0] DIV_42 = 6'd42;
    localparam logic [5:0] DIV_20 = 6'd20;
    localparam logic [5:0] DIV_6  = 6'd6;
    localparam logic [5:0] DIV_56 = 6'd56;
    localparam logic [5:0] DIV_30 = 6'd30;
    localparam logic [5:0] DIV_12 = 6'd12;

    // Quotient estimate; it is either the true quotient or one below it.
    function automatic logic [29:0] div_est(input logic [29:0] v, input logic [31:0] recip);
        logic [61:0] prod;
        prod = 62'(v) * 62'(recip);
        return prod[61:32];
    endfunction

    // One compare-and-correct step that turns the estimate into floor(v / d).
    function automatic logic [29:0] div_fix(input logic [29:0] v, input logic [29:0] q0,
                                            input logic [5:0] d);
        logic [35:0] rem;
        rem = 36'(v) - 36'(q0) * 36'(d);
        return (rem >= 36'(d)) ? q0 + 30'd1 : q0;
    endfunction

    // Round a Q30 value to Q15 and cap at the largest positive Q1.15 value.
    function automatic logic [14:0] q15_round(input logic [30:0] v);
        logic [31:0] sum;
        sum = 32'(v) + 32'd16384;
        return (sum[31:15] > 17'd32767) ? 15'h7FFF : sum[29:15];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/polar_scan_to_cartesian.sv -----
// ----------------------------------------------------------------------------
// polar_scan_to_cartesian
// Converts a range sensor sample (beam index, range) into a world point with
// configurable mirror mode, rotation and sensor offset.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// in        sink       i_in_valid / o_in_ready      i_beam_index, i_range_mm
// out       source     o_out_valid / i_out_ready    o_point_index, o_point_x_mm,
//                                                   o_point_y_mm
// cfg       sink       i_cfg_we                     i_cfg_index, i_cfg_data
//
// One sample is taken per cycle while o_in_ready is high. The pipeline length
// is set by the chain of Q30 multiplier stages of the sine and cosine Horner
// evaluation, each divide taking an estimate and a correction stage. Reset
// clears the pipeline valid bits and the configuration registers. A full stage
// holds only while the stage after it holds, so bubbles close up; with the
// output stalled, input transfers go on until all 17 stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_scan_to_cartesian (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [9:0]                    i_beam_index,
    input  wire logic [15:0]                   i_range_mm,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [9:0]                         o_point_index,
    output logic signed [17:0]                 o_point_x_mm,
    output logic signed [17:0]                 o_point_y_mm,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [pstc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LAST = pstc_pkg::PIPE_DEPTH - 1;

    // Configuration registers.
    logic               r_mirror;
    logic [15:0]        r_rotation;
    logic signed [16:0] r_offset_x;
    logic signed [16:0] r_offset_y;

    // Pipeline control.
    logic [LAST:0] r_vld;
    logic [LAST:0] w_en;

    // Carried fields.
    logic [9:0]  r_idx  [0:LAST];
    logic [15:0] r_rng  [0:LAST-2];
    logic [1:0]  r_quad [1:13];
    logic        r_tneg [1:13];
    logic [29:0] r_x    [2:11];
    logic [29:0] r_x2   [3:11];

    // Stage results.
    logic [15:0]        r_angle;
    logic [13:0]        r_mag;
    logic [29:0]        r_qs0_a, r_qc0_a;
    logic [30:0]        r_us_a, r_uc_a;
    logic [29:0]        r_ws_a, r_wc_a;
    logic [29:0]        r_qs0_b, r_qc0_b;
    logic [29:0]        r_ws_b_hold, r_wc_b_hold;
    logic [30:0]        r_us_b, r_uc_b;
    logic [29:0]        r_ws_b, r_wc_b;
    logic [29:0]        r_qs0_c, r_qc0_c;
    logic [29:0]        r_ws_c_hold, r_wc_c_hold;
    logic [30:0]        r_us_c, r_uc_c;
    logic [29:0]        r_sin_q30, r_wc_c;
    logic [14:0]        r_cos_mag, r_sin_mag;
    logic signed [15:0] r_cos, r_sin;
    logic signed [32:0] r_prod_x, r_prod_y;
    logic signed [17:0] r_out_x, r_out_y;

    // Next values.
    logic [26:0]        n_base_full;
    logic [15:0]        n_base;
    logic [15:0]        n_angle;
    logic [15:0]        n_shift;
    logic [13:0]        n_mag;
    logic [44:0]        n_x_prod;
    logic [59:0]        n_x2_prod;
    logic [60:0]        n_ws_a_prod, n_wc_a_prod;
    logic [60:0]        n_ws_b_prod, n_wc_b_prod;
    logic [60:0]        n_sin_prod, n_wc_c_prod;
    logic [30:0]        n_cos_q30;
    logic signed [15:0] n_sin_signed;
    logic signed [15:0] n_cos, n_sin;
    logic signed [34:0] n_sum_x, n_sum_y;
    logic signed [17:0] n_out_x, n_out_y;

    function automatic logic signed [17:0] sat18(input logic signed [34:0] sum);
        logic signed [19:0] v;
        v = sum[34:15];
        if (v > 20'sd131071) begin
            return 18'sd131071;
        end else if (v < -20'sd131072) begin
            return -18'sd131072;
        end else begin
            return v[17:0];
        end
    endfunction

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror   <= 1'b0;
            r_rotation <= '0;
            r_offset_x <= '0;
            r_offset_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pstc_pkg::CFG_MIRROR:   r_mirror   <= i_cfg_data[0];
                pstc_pkg::CFG_ROTATION: r_rotation <= i_cfg_data[15:0];
                pstc_pkg::CFG_OFFSET_X: r_offset_x <= $signed(i_cfg_data[16:0]);
                pstc_pkg::CFG_OFFSET_Y: r_offset_y <= $signed(i_cfg_data[16:0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------------
    always_comb begin
        w_en[LAST] = !r_vld[LAST] || i_out_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath arithmetic
    // ------------------------------------------------------------------------
    always_comb begin
        // Stage 0: beam angle, rounded to the nearest binary angle unit.
        n_base_full = ({1'b0, i_beam_index, 16'b0} + 27'(pstc_pkg::BEAMS_PER_TURN / 2))
                      >> pstc_pkg::BASE_SHIFT;
        n_base  = n_base_full[15:0];
        n_angle = (r_mirror ? (16'd0 - n_base) : n_base)
                + (r_mirror ? pstc_pkg::ANG_OFS_MIRROR : pstc_pkg::ANG_OFS_NORMAL)
                + r_rotation;

        // Stage 1: quadrant and residue magnitude, residue in [-8192, 8191].
        n_shift = r_angle + pstc_pkg::ANG_QUARTER_HALF;
        if (n_shift[13]) begin
            n_mag = {1'b0, n_shift[12:0]};
        end else begin
            n_mag = 14'd8192 - {1'b0, n_shift[12:0]};
        end

        n_x_prod  = 45'(r_mag) * 45'(pstc_pkg::TWO_PI_Q28);
        n_x2_prod = 60'(r_x[2]) * 60'(r_x[2]);

        n_ws_a_prod = 61'(r_x2[5]) * 61'(r_us_a);
        n_wc_a_prod = 61'(r_x2[5]) * 61'(r_uc_a);
        n_ws_b_prod = 61'(r_x2[8]) * 61'(r_us_b);
        n_wc_b_prod = 61'(r_x2[8]) * 61'(r_uc_b);
        n_sin_prod  = 61'(r_x[11]) * 61'(r_us_c);
        n_wc_c_prod = 61'(r_x2[11]) * 61'(r_uc_c);

        n_cos_q30 = pstc_pkg::Q30_ONE - 31'(r_wc_c[29:1]);

        // Quadrant rotation.
        n_sin_signed = r_tneg[13] ? -$signed({1'b0, r_sin_mag}) : $signed({1'b0, r_sin_mag});
        case (r_quad[13])
            2'd0: begin
                n_cos = $signed({1'b0, r_cos_mag});
                n_sin = n_sin_signed;
            end
            2'd1: begin
                n_cos = -n_sin_signed;
                n_sin = $signed({1'b0, r_cos_mag});
            end
            2'd2: begin
                n_cos = -$signed({1'b0, r_cos_mag});
                n_sin = -n_sin_signed;
            end
            default: begin
                n_cos = n_sin_signed;
                n_sin = -$signed({1'b0, r_cos_mag});
            end
        endcase

        // Offset in Q15, half for round half up, then floor back to mm.
        n_sum_x = 35'(r_prod_x) + (35'(r_offset_x) <<< 15) + 35'sd16384;
        n_sum_y = 35'(r_prod_y) + (35'(r_offset_y) <<< 15) + 35'sd16384;
        n_out_x = sat18(n_sum_x);
        n_out_y = sat18(n_sum_y);
    end

    // ------------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_idx[0] <= i_beam_index;
            r_rng[0] <= i_range_mm;
            r_angle  <= n_angle;
        end
        for (int k = 1; k <= LAST; k++) begin
            if (w_en[k]) begin
                r_idx[k] <= r_idx[k-1];
            end
        end
        for (int k = 1; k <= LAST - 2; k++) begin
            if (w_en[k]) begin
                r_rng[k] <= r_rng[k-1];
            end
        end

        if (w_en[1]) begin
            r_quad[1] <= n_shift[15:14];
            r_tneg[1] <= !n_shift[13];
            r_mag     <= n_mag;
        end
        for (int k = 2; k <= 13; k++) begin
            if (w_en[k]) begin
                r_quad[k] <= r_quad[k-1];
                r_tneg[k] <= r_tneg[k-1];
            end
        end

        if (w_en[2]) begin
            r_x[2] <= n_x_prod[43:14];
        end
        for (int k = 3; k <= 11; k++) begin
            if (w_en[k]) begin
                r_x[k] <= r_x[k-1];
            end
        end

        if (w_en[3]) begin
            r_x2[3] <= n_x2_prod[59:30];
        end
        for (int k = 4; k <= 11; k++) begin
            if (w_en[k]) begin
                r_x2[k] <= r_x2[k-1];
            end
        end

        // First Horner step: 1 - x^2/42 and 1 - x^2/56.
        if (w_en[4]) begin
            r_qs0_a <= pstc_pkg::div_est(r_x2[3], pstc_pkg::RECIP_42);
            r_qc0_a <= pstc_pkg::div_est(r_x2[3], pstc_pkg::RECIP_56);
        end
        if (w_en[5]) begin
            r_us_a <= pstc_pkg::Q30_ONE
                    - 31'(pstc_pkg::div_fix(r_x2[4], r_qs0_a, pstc_pkg::DIV_42));
            r_uc_a <= pstc_pkg::Q30_ONE
                    - 31'(pstc_pkg::div_fix(r_x2[4], r_qc0_a, pstc_pkg::DIV_56));
        end
        if (w_en[6]) begin
            r_ws_a <= n_ws_a_prod[59:30];
            r_wc_a <= n_wc_a_prod[59:30];
        end

        // Second step: divide by 20 and 30.
        if (w_en[7]) begin
            r_qs0_b     <= pstc_pkg::div_est(r_ws_a, pstc_pkg::RECIP_20);
            r_qc0_b     <= pstc_pkg::div_est(r_wc_a, pstc_pkg::RECIP_30);
            r_ws_b_hold <= r_ws_a;
            r_wc_b_hold <= r_wc_a;
        end
        if (w_en[8]) begin
            r_us_b <= pstc_pkg::Q30_ONE
                    - 31'(pstc_pkg::div_fix(r_ws_b_hold, r_qs0_b, pstc_pkg::DIV_20));
            r_uc_b <= pstc_pkg::Q30_ONE
                    - 31'(pstc_pkg::div_fix(r_wc_b_hold, r_qc0_b, pstc_pkg::DIV_30));
        end
        if (w_en[9]) begin
            r_ws_b <= n_ws_b_prod[59:30];
            r_wc_b <= n_wc_b_prod[59:30];
        end

        // Third step: divide by 6 and 12.
        if (w_en[10]) begin
            r_qs0_c     <= pstc_pkg::div_est(r_ws_b, pstc_pkg::RECIP_6);
            r_qc0_c     <= pstc_pkg::div_est(r_wc_b, pstc_pkg::RECIP_12);
            r_ws_c_hold <= r_ws_b;
            r_wc_c_hold <= r_wc_b;
        end
        if (w_en[11]) begin
            r_us_c <= pstc_pkg::Q30_ONE
                    - 31'(pstc_pkg::div_fix(r_ws_c_hold, r_qs0_c, pstc_pkg::DIV_6));
            r_uc_c <= pstc_pkg::Q30_ONE
                    - 31'(pstc_pkg::div_fix(r_wc_c_hold, r_qc0_c, pstc_pkg::DIV_12));
        end

        // Sine closes with x * u; cosine needs one more x^2 * u.
        if (w_en[12]) begin
            r_sin_q30 <= n_sin_prod[59:30];
            r_wc_c    <= n_wc_c_prod[59:30];
        end
        if (w_en[13]) begin
            r_cos_mag <= pstc_pkg::q15_round(n_cos_q30);
            r_sin_mag <= pstc_pkg::q15_round({1'b0, r_sin_q30});
        end
        if (w_en[14]) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
        if (w_en[15]) begin
            r_prod_x <= $signed({1'b0, r_rng[14]}) * r_cos;
            r_prod_y <= $signed({1'b0, r_rng[14]}) * r_sin;
        end
        if (w_en[16]) begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
        end
    end

    assign o_in_ready    = w_en[0];
    assign o_out_valid   = r_vld[LAST];
    assign o_point_index = r_idx[LAST];
    assign o_point_x_mm  = r_out_x;
    assign o_point_y_mm  = r_out_y;

endmodule

`default_nettype wire

// ----- hw/rtl/pstc_checker.sv -----
// ----------------------------------------------------------------------------
// pstc_checker
// Port-level checks of the polar scan to Cartesian converter, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pstc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [9:0]          o_point_index,
    input wire logic signed [17:0]  o_point_x_mm,
    input wire logic signed [17:0]  o_point_y_mm
);

    localparam int CNT_W = $clog2(pstc_pkg::PIPE_DEPTH + 1);

    // Points accepted but not yet transferred out.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count
                + CNT_W'(i_in_valid && o_in_ready)
                - CNT_W'(o_out_valid && i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    `ASSERT_CLK_ALL(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid)

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_point_index) && $stable(o_point_x_mm) && $stable(o_point_y_mm))

    `ASSERT_CLK(a_no_invented, i_clk, i_rst_n, o_out_valid |-> r_count != '0)

    `ASSERT_CLK(a_depth_bound, i_clk, i_rst_n, r_count <= CNT_W'(pstc_pkg::PIPE_DEPTH))

endmodule

bind polar_scan_to_cartesian pstc_checker u_pstc_checker (.*);

`default_nettype wire
